// ===== src/fdu_pkg.sv =====
// Package for the fragmented frame deframer: field types, result codes and limits.
// Depends on nothing; every other file of the block imports it.
`default_nettype none
package fdu_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [1:0]  kind_t;
    typedef logic [9:0]  off_t;
    typedef logic [10:0] len_t;
    typedef logic [2:0]  err_t;

    // Result kinds.
    localparam kind_t KIND_PAYLOAD  = 2'd0;
    localparam kind_t KIND_COMPLETE = 2'd1;
    localparam kind_t KIND_ABORT    = 2'd2;

    // Abort codes.
    localparam err_t ERR_NONE     = 3'd0;
    localparam err_t ERR_SYNC     = 3'd1;
    localparam err_t ERR_LENGTH   = 3'd2;
    localparam err_t ERR_FIRST    = 3'd3;
    localparam err_t ERR_SEQUENCE = 3'd4;
    localparam err_t ERR_CHECKSUM = 3'd5;
    localparam err_t ERR_OVERFLOW = 3'd6;

    // Framing constants.
    localparam byte_t SYNC0 = 8'hAA;
    localparam byte_t SYNC1 = 8'h55;
    localparam byte_t FRAG_MAX = 8'd31;
    localparam len_t  MSG_MAX = 11'd1024;
    localparam len_t  CAP_RESET = 11'd256;

    typedef struct packed {
        kind_t kind;
        byte_t payload_byte;
        off_t  byte_offset;
        len_t  total_length;
        err_t  error_code;
    } res_t;

    typedef struct packed {
        logic valid;
        res_t res;
    } push_t;

endpackage
`default_nettype wire

// ===== src/fdu_rx_if.sv =====
// Input byte channel of the deframer: valid, ready and the received byte.
// Depends on fdu_pkg.
`default_nettype none
interface fdu_rx_if;
    import fdu_pkg::*;
    logic  valid;
    logic  ready;
    byte_t rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== src/fdu_res_if.sv =====
// Result channel of the deframer: valid, ready and the result fields.
// Depends on fdu_pkg.
`default_nettype none
interface fdu_res_if;
    import fdu_pkg::*;
    logic  valid;
    logic  ready;
    kind_t kind;
    byte_t payload_byte;
    off_t  byte_offset;
    len_t  total_length;
    err_t  error_code;
    modport source (output valid, output kind, output payload_byte, output byte_offset,
                    output total_length, output error_code, input ready);
    modport sink (input valid, input kind, input payload_byte, input byte_offset,
                  input total_length, input error_code, output ready);
endinterface
`default_nettype wire

// ===== src/fdu_cfg_if.sv =====
// Configuration write channel of the deframer: valid, ready and the capacity value.
// Depends on fdu_pkg.
`default_nettype none
interface fdu_cfg_if;
    import fdu_pkg::*;
    logic valid;
    logic ready;
    len_t max_message_bytes;
    modport source (output valid, output max_message_bytes, input ready);
    modport sink (input valid, input max_message_bytes, output ready);
endinterface
`default_nettype wire

// ===== src/fdu_core.sv =====
// Per-byte deframing logic and message state of the deframer.
// Depends on fdu_pkg.
`default_nettype none
module fdu_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           fire,
    input  wire fdu_pkg::byte_t rx_byte,
    input  wire fdu_pkg::len_t  cap,
    output fdu_pkg::push_t      push
);
    import fdu_pkg::*;

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_CHECK   = 2'd2;

    logic [1:0]  phase_reg, phase_next;
    logic [2:0]  hdr_cnt_reg, hdr_cnt_next;
    byte_t       hs_reg [2:6];
    byte_t       hs_next [2:6];
    logic [4:0]  frag_len_reg, frag_len_next;
    logic [4:0]  frag_pos_reg, frag_pos_next;
    byte_t       xor_reg, xor_next;
    logic [15:0] cur_frag_reg, cur_frag_next;
    logic [15:0] frag_tot_reg, frag_tot_next;
    len_t        msg_len_reg, msg_len_next;
    logic        in_msg_reg, in_msg_next;

    logic        sync_bad;
    logic        len_bad;
    logic [15:0] num;
    logic [15:0] cnt;
    len_t        base;
    logic [11:0] need;
    logic        no_room;
    logic [4:0]  pos_inc;
    res_t        res;
    logic        res_valid;

    always_comb
    begin
        num      = {hs_reg[5], hs_reg[4]};
        cnt      = {rx_byte, hs_reg[6]};
        len_bad  = (hs_reg[2] != 8'd0) || (hs_reg[3] == 8'd0) || (hs_reg[3] > FRAG_MAX);
        base     = in_msg_reg ? msg_len_reg : '0;
        need     = {1'b0, base} + {7'd0, hs_reg[3][4:0]} + 12'd1;
        no_room  = need > {1'b0, cap};
        sync_bad = ((hdr_cnt_reg == 3'd0) && (rx_byte != SYNC0)) ||
                   ((hdr_cnt_reg == 3'd1) && (rx_byte != SYNC1));
        pos_inc  = frag_pos_reg + 5'd1;
    end

    always_comb
    begin
        phase_next    = phase_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        hs_next       = hs_reg;
        frag_len_next = frag_len_reg;
        frag_pos_next = frag_pos_reg;
        xor_next      = xor_reg;
        cur_frag_next = cur_frag_reg;
        frag_tot_next = frag_tot_reg;
        msg_len_next  = msg_len_reg;
        in_msg_next   = in_msg_reg;
        res           = '0;
        res_valid     = 1'b0;

        case (phase_reg)
            PH_PAYLOAD:
            begin
                res_valid        = 1'b1;
                res.kind         = KIND_PAYLOAD;
                res.payload_byte = rx_byte;
                res.byte_offset  = msg_len_reg[9:0];
                xor_next         = xor_reg ^ rx_byte;
                msg_len_next     = msg_len_reg + 11'd1;
                frag_pos_next    = pos_inc;
                if (pos_inc >= frag_len_reg)
                begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK:
            begin
                phase_next   = PH_HEADER;
                hdr_cnt_next = 3'd0;
                if (rx_byte != xor_reg)
                begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_ABORT;
                    res.error_code = ERR_CHECKSUM;
                    in_msg_next    = 1'b0;
                end
                else if (cur_frag_reg == frag_tot_reg)
                begin
                    res_valid        = 1'b1;
                    res.kind         = KIND_COMPLETE;
                    res.total_length = msg_len_reg;
                    in_msg_next      = 1'b0;
                end
            end
            default:
            begin
                if (sync_bad)
                begin
                    // A broken sync inside a message aborts it; the byte may restart a header.
                    if (in_msg_reg)
                    begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_ABORT;
                        res.error_code = ERR_SYNC;
                        in_msg_next    = 1'b0;
                    end
                    hdr_cnt_next = (rx_byte == SYNC0) ? 3'd1 : 3'd0;
                end
                else if (hdr_cnt_reg != 3'd7)
                begin
                    case (hdr_cnt_reg)
                        3'd2: hs_next[2] = rx_byte;
                        3'd3: hs_next[3] = rx_byte;
                        3'd4: hs_next[4] = rx_byte;
                        3'd5: hs_next[5] = rx_byte;
                        3'd6: hs_next[6] = rx_byte;
                        default: ;
                    endcase
                    hdr_cnt_next = hdr_cnt_reg + 3'd1;
                end
                else
                begin
                    hdr_cnt_next   = 3'd0;
                    res.kind       = KIND_ABORT;
                    if (len_bad)
                    begin
                        res.error_code = ERR_LENGTH;
                    end
                    else if (!in_msg_reg)
                    begin
                        if (num != 16'd1)
                        begin
                            res.error_code = ERR_FIRST;
                        end
                        else if ((cnt == 16'd0) || no_room)
                        begin
                            res.error_code = ERR_OVERFLOW;
                        end
                    end
                    else if ((num != cur_frag_reg + 16'd1) || (cnt != frag_tot_reg))
                    begin
                        res.error_code = ERR_SEQUENCE;
                    end
                    else if (no_room)
                    begin
                        res.error_code = ERR_OVERFLOW;
                    end

                    if (res.error_code != ERR_NONE)
                    begin
                        res_valid   = 1'b1;
                        in_msg_next = 1'b0;
                    end
                    else
                    begin
                        res.kind = KIND_PAYLOAD;
                        if (!in_msg_reg)
                        begin
                            msg_len_next  = '0;
                            frag_tot_next = cnt;
                        end
                        in_msg_next   = 1'b1;
                        cur_frag_next = num;
                        frag_len_next = hs_reg[3][4:0];
                        frag_pos_next = 5'd0;
                        xor_next      = 8'd0;
                        phase_next    = PH_PAYLOAD;
                    end
                end
            end
        endcase
    end

    assign push.valid = fire && res_valid;
    assign push.res   = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            hdr_cnt_reg  <= 3'd0;
            hs_reg       <= '{default: 8'd0};
            frag_len_reg <= 5'd0;
            frag_pos_reg <= 5'd0;
            xor_reg      <= 8'd0;
            cur_frag_reg <= 16'd0;
            frag_tot_reg <= 16'd0;
            msg_len_reg  <= '0;
            in_msg_reg   <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            hs_reg       <= hs_next;
            frag_len_reg <= frag_len_next;
            frag_pos_reg <= frag_pos_next;
            xor_reg      <= xor_next;
            cur_frag_reg <= cur_frag_next;
            frag_tot_reg <= frag_tot_next;
            msg_len_reg  <= msg_len_next;
            in_msg_reg   <= in_msg_next;
        end
    end

    // Payload and checksum bytes only occur inside an open message.
    a_phase_in_msg: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_HEADER) |-> in_msg_reg)
        else $error("payload or checksum phase without an open message");

    // The fragment position stays below the fragment length while payload is taken.
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (frag_pos_reg < frag_len_reg))
        else $error("fragment position ran past the fragment length");

    // The capacity check keeps the message within the largest buffer.
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_msg_reg |-> (msg_len_reg < MSG_MAX))
        else $error("message length exceeds the buffer limit");

endmodule
`default_nettype wire

// ===== src/fdu_obuf.sv =====
// Two-entry output buffer of the deframer that drives the result channel.
// Depends on fdu_pkg and fdu_res_if.
`default_nettype none
module fdu_obuf (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire fdu_pkg::push_t push,
    output logic                space,
    fdu_res_if.source           res
);
    import fdu_pkg::*;

    logic [1:0] cnt_reg, cnt_next;
    res_t       head_reg;
    res_t       tail_reg;
    logic       pop;

    assign pop   = (cnt_reg != 2'd0) && res.ready;
    assign space = (cnt_reg != 2'd2);

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, push.valid} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (cnt_reg == 2'd2)
            begin
                head_reg <= tail_reg;
            end
            else if (push.valid)
            begin
                head_reg <= push.res;
            end
        end
        else if (push.valid)
        begin
            if (cnt_reg == 2'd0)
            begin
                head_reg <= push.res;
            end
            else
            begin
                tail_reg <= push.res;
            end
        end
    end

    assign res.valid        = (cnt_reg != 2'd0);
    assign res.kind         = head_reg.kind;
    assign res.payload_byte = head_reg.payload_byte;
    assign res.byte_offset  = head_reg.byte_offset;
    assign res.total_length = head_reg.total_length;
    assign res.error_code   = head_reg.error_code;

    // Nothing is written into a full buffer.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> (cnt_reg != 2'd2))
        else $error("result pushed into a full output buffer");

    // The fill count goes up by one on a push without a pop.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push.valid && !pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("output buffer count did not follow a push");

endmodule
`default_nettype wire

// ===== src/fragmented_frame_deframer_unit.sv =====
// Top level of the fragmented frame deframer: input register, capacity register,
// per-byte deframing core and output buffer. Depends on fdu_pkg, the three channel
// interfaces, fdu_core and fdu_obuf.
//
// Usage: received link bytes enter on the rx channel, one item per byte. Each
// fragment is an 8-byte header (AA 55, big-endian length 1..31, little-endian
// number and count), the payload and an XOR checksum byte. Results leave on the
// res channel: one item per payload byte, one when a message completes and one
// when a message is aborted; bytes that are only header or checksum give none.
// The cfg channel writes the receive capacity; write it only while idle.
// Path: an accepted byte is held in the input register, handled by the core and
// written into the output buffer, which offers its result on res.
// Throughput: one byte per cycle while the output buffer has room, since each
// byte needs only a compare, an XOR and counter updates between the input
// register and the output buffer. When the receiver stalls, the two-entry output
// buffer fills and then rx.ready drops until room is made. Reset clears all
// message state, sets the capacity to 256 and starts hunting for a header.
`default_nettype none
module fragmented_frame_deframer_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    fdu_rx_if.sink    rx,
    fdu_res_if.source res,
    fdu_cfg_if.sink   cfg
);
    import fdu_pkg::*;

    // Input register: holds one accepted byte until the core takes it.
    logic  s1_valid_reg;
    byte_t s1_byte_reg;
    logic  s1_fire;

    // Capacity register, capped at the largest supported message.
    len_t  cap_reg;
    len_t  cap_eff;

    push_t push;
    logic  space;

    // The core consumes the held byte whenever the output buffer has room, so a
    // new byte can enter in the same cycle.
    assign s1_fire  = s1_valid_reg && space;
    assign rx.ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            s1_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            s1_byte_reg <= rx.rx_byte;
        end
    end

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg.valid)
        begin
            cap_reg <= cfg.max_message_bytes;
        end
    end

    assign cap_eff = (cap_reg > MSG_MAX) ? MSG_MAX : cap_reg;

    fdu_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (s1_fire),
        .rx_byte (s1_byte_reg),
        .cap     (cap_eff),
        .push    (push)
    );

    fdu_obuf u_obuf (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .space (space),
        .res   (res)
    );

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the fragmented frame deframer unit.
// Depends on fdu_pkg, the three channel interfaces and fragmented_frame_deframer_unit.
`timescale 1ns / 1ps
module tb_top;
    import fdu_pkg::*;

    // Results leave the block through its input register and output buffer; the
    // drain wait is well above the result latency, so the pipeline runs dry.
    localparam int RESULT_LATENCY = 2;
    localparam int DRAIN_CYCLES   = 4 * RESULT_LATENCY + 4;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int HOLD_CYCLES    = 300;
    localparam int REPORT_LIMIT   = 10;

    // Phases of the deframer as the predictor tracks them.
    typedef enum logic [1:0] {
        ST_HEADER,
        ST_PAYLOAD,
        ST_CHECKSUM
    } dfm_phase_e;

    logic clk = 1'b0;
    logic rst_n;

    fdu_rx_if  rx_ch ();
    fdu_res_if res_ch ();
    fdu_cfg_if cfg_ch ();

    fragmented_frame_deframer_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    always #6 clk = ~clk;

    // Predictor state: our own copy of the framing state and the capacity.
    dfm_phase_e  dphase;
    int          hdr_fill;
    byte_t       hdr_bytes [8];
    int          seg_len;
    int          seg_idx;
    byte_t       seg_xor;
    logic [15:0] frag_no;
    logic [15:0] frag_cnt;
    len_t        msg_bytes;
    bit          msg_open;
    len_t        capacity;

    // Results that the predictor says the block still owes us, oldest first.
    res_t frame_results_due [$];

    // Handshake pacing and run bookkeeping.
    int unsigned snd_idle_pct = 0;
    int unsigned rcv_idle_pct = 0;
    bit          hold_off = 1'b0;
    int          bytes_sent = 0;
    int          results_seen = 0;
    int          completes_seen = 0;
    int          aborts_seen = 0;
    int          cap_writes = 0;
    int          mismatches = 0;
    int          cycle_count = 0;

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------

    function automatic void reset_model();
        dphase    = ST_HEADER;
        hdr_fill  = 0;
        foreach (hdr_bytes[i])
            hdr_bytes[i] = '0;
        seg_len   = 0;
        seg_idx   = 0;
        seg_xor   = '0;
        frag_no   = '0;
        frag_cnt  = '0;
        msg_bytes = '0;
        msg_open  = 1'b0;
        capacity  = CAP_RESET;
    endfunction

    function automatic void post_result(input kind_t k, input byte_t pb, input off_t off,
                                        input len_t tot, input err_t err);
        res_t r;
        r.kind         = k;
        r.payload_byte = pb;
        r.byte_offset  = off;
        r.total_length = tot;
        r.error_code   = err;
        frame_results_due.push_back(r);
    endfunction

    function automatic void abort_message(input err_t err);
        msg_open = 1'b0;
        dphase   = ST_HEADER;
        hdr_fill = 0;
        post_result(KIND_ABORT, '0, '0, '0, err);
    endfunction

    // A byte that breaks the sync starts the hunt over; an AA counts as the
    // first sync byte of a new header.
    function automatic void restart_hunt(input byte_t b);
        dphase = ST_HEADER;
        if (b == SYNC0)
        begin
            hdr_bytes[0] = b;
            hdr_fill     = 1;
        end
        else
        begin
            hdr_fill = 0;
        end
    endfunction

    // Header checks, run when the eighth header byte has arrived. The order
    // of the checks decides which code is reported.
    function automatic void check_header();
        logic [15:0] flen;
        logic [15:0] fnum;
        logic [15:0] fcnt;
        logic [15:0] next_no;
        int          cap_now;
        int          base;
        flen    = {hdr_bytes[2], hdr_bytes[3]};
        fnum    = {hdr_bytes[5], hdr_bytes[4]};
        fcnt    = {hdr_bytes[7], hdr_bytes[6]};
        next_no = frag_no + 16'd1;
        cap_now = (capacity > MSG_MAX) ? int'(MSG_MAX) : int'(capacity);
        hdr_fill = 0;
        if (flen == 16'd0 || flen > FRAG_MAX)
        begin
            abort_message(ERR_LENGTH);
            return;
        end
        if (!msg_open)
        begin
            if (fnum != 16'd1)
            begin
                abort_message(ERR_FIRST);
                return;
            end
            if (fcnt == 16'd0)
            begin
                abort_message(ERR_OVERFLOW);
                return;
            end
            base = 0;
        end
        else
        begin
            if (fnum != next_no || fcnt != frag_cnt)
            begin
                abort_message(ERR_SEQUENCE);
                return;
            end
            base = int'(msg_bytes);
        end
        if (base + int'(flen) + 1 > cap_now)
        begin
            abort_message(ERR_OVERFLOW);
            return;
        end
        if (!msg_open)
        begin
            msg_open  = 1'b1;
            msg_bytes = '0;
            frag_cnt  = fcnt;
        end
        frag_no = fnum;
        seg_len = int'(flen);
        seg_idx = 0;
        seg_xor = '0;
        dphase  = ST_PAYLOAD;
    endfunction

    // Advances the predictor by one received byte and queues what it causes.
    function automatic void deframe_byte(input byte_t b);
        if (dphase == ST_PAYLOAD)
        begin
            post_result(KIND_PAYLOAD, b, msg_bytes[9:0], '0, ERR_NONE);
            seg_xor   = seg_xor ^ b;
            msg_bytes = msg_bytes + 11'd1;
            seg_idx++;
            if (seg_idx >= seg_len)
                dphase = ST_CHECKSUM;
        end
        else if (dphase == ST_CHECKSUM)
        begin
            if (b != seg_xor)
            begin
                abort_message(ERR_CHECKSUM);
            end
            else
            begin
                dphase   = ST_HEADER;
                hdr_fill = 0;
                if (frag_no == frag_cnt)
                begin
                    msg_open = 1'b0;
                    post_result(KIND_COMPLETE, '0, '0, msg_bytes, ERR_NONE);
                end
            end
        end
        else if ((hdr_fill == 0 && b != SYNC0) || (hdr_fill == 1 && b != SYNC1))
        begin
            // Inside a message a broken sync is an abort; outside it is silent.
            if (msg_open)
                abort_message(ERR_SYNC);
            restart_hunt(b);
        end
        else
        begin
            hdr_bytes[hdr_fill] = b;
            hdr_fill++;
            if (hdr_fill >= 8)
                check_header();
        end
    endfunction

    //------------------------------------------------------------------
    // Result side: random ready, the long hold-off and the checker
    //------------------------------------------------------------------

    always @(posedge clk)
        res_ch.ready <= rst_n && !hold_off && ($urandom_range(99) >= rcv_idle_pct);

    // Every result taken is compared, field by field, with the oldest one due.
    always @(posedge clk)
    begin
        res_t due;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            results_seen++;
            if (res_ch.kind == KIND_COMPLETE)
                completes_seen++;
            if (res_ch.kind == KIND_ABORT)
                aborts_seen++;
            if (frame_results_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] unexpected result: kind=%0d byte=%02h off=%0d len=%0d err=%0d",
                             $realtime, res_ch.kind, res_ch.payload_byte, res_ch.byte_offset,
                             res_ch.total_length, res_ch.error_code);
            end
            else
            begin
                due = frame_results_due.pop_front();
                if (res_ch.kind !== due.kind || res_ch.payload_byte !== due.payload_byte ||
                    res_ch.byte_offset !== due.byte_offset ||
                    res_ch.total_length !== due.total_length ||
                    res_ch.error_code !== due.error_code)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("[%0t] mismatch: expected kind=%0d byte=%02h off=%0d len=%0d err=%0d",
                                 $realtime, due.kind, due.payload_byte, due.byte_offset,
                                 due.total_length, due.error_code);
                        $display("             actual kind=%0d byte=%02h off=%0d len=%0d err=%0d",
                                 res_ch.kind, res_ch.payload_byte, res_ch.byte_offset,
                                 res_ch.total_length, res_ch.error_code);
                    end
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycle_count, frame_results_due.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Stimulus helpers
    //------------------------------------------------------------------

    // Offers one received byte, with random idle cycles in front of it, and
    // feeds the predictor at the edge where the block takes the item.
    task automatic send_byte(input byte_t b);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        deframe_byte(b);
        bytes_sent++;
    endtask

    // Builds one fragment on the wire. The header fields go out as given, so
    // that broken headers can be sent; nbytes payload bytes follow, then the
    // XOR checksum, optionally with one bit flipped.
    task automatic send_fragment(input logic [15:0] flen, input logic [15:0] fnum,
                                 input logic [15:0] fcnt, input int nbytes, input bit bad_sum);
        byte_t sum;
        byte_t b;
        sum = '0;
        send_byte(SYNC0);
        send_byte(SYNC1);
        send_byte(flen[15:8]);
        send_byte(flen[7:0]);
        send_byte(fnum[7:0]);
        send_byte(fnum[15:8]);
        send_byte(fcnt[7:0]);
        send_byte(fcnt[15:8]);
        for (int i = 0; i < nbytes; i++)
        begin
            b   = byte_t'($urandom);
            sum = sum ^ b;
            send_byte(b);
        end
        if (bad_sum)
            sum = sum ^ byte_t'(1 << $urandom_range(7));
        send_byte(sum);
    endtask

    // Line noise, weighted toward the sync bytes so that false starts occur.
    task automatic send_noise(input int n);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(3))
                0: send_byte(SYNC0);
                1: send_byte(SYNC1);
                default: send_byte(byte_t'($urandom));
            endcase
        end
    endtask

    // A message of random length split into fragments. With fault_pct chance
    // one fragment is damaged; the rest of the message still goes out, which
    // exercises what the block does with orphaned fragments.
    task automatic send_random_message(input int max_frags, input int fault_pct);
        int          nfrag;
        int          fault_at;
        int          plen;
        int          nbytes;
        logic [15:0] flen;
        logic [15:0] fnum;
        logic [15:0] fcnt;
        bit          bad_sum;
        nfrag    = $urandom_range(1, max_frags);
        fault_at = ($urandom_range(99) < fault_pct) ? int'($urandom_range(nfrag - 1)) : -1;
        for (int i = 0; i < nfrag; i++)
        begin
            plen    = ($urandom_range(7) == 0) ? 31 : $urandom_range(1, 31);
            nbytes  = plen;
            flen    = 16'(plen);
            fnum    = 16'(i + 1);
            fcnt    = 16'(nfrag);
            bad_sum = 1'b0;
            if (i == fault_at)
            begin
                case ($urandom_range(7))
                    0: flen = 16'd0;
                    1: flen = 16'($urandom_range(32, 65535));
                    2: fnum = fnum ^ 16'(1 << $urandom_range(15));
                    3: fcnt = fcnt ^ 16'(1 << $urandom_range(15));
                    4: bad_sum = 1'b1;
                    5: send_noise($urandom_range(1, 6));
                    6: nbytes = $urandom_range(plen - 1);
                    default: fcnt = 16'd0;
                endcase
            end
            send_fragment(flen, fnum, fcnt, nbytes, bad_sum);
        end
    endtask

    // Lowers valid and waits until every result due has arrived, then waits out
    // the drain time, since a checksum byte may still be in flight with no result.
    task automatic wait_idle();
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (frame_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input len_t value);
        wait_idle();
        cfg_ch.valid             <= 1'b1;
        cfg_ch.max_message_bytes <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        capacity = value;
        cap_writes++;
    endtask

    task automatic hold_receiver(input int cycles);
        hold_off <= 1'b1;
        repeat (cycles) @(posedge clk);
        hold_off <= 1'b0;
    endtask

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    // Good messages and every abort code, at the capacity left by reset.
    task automatic test_directed_framing();
        // Shortest and longest single-fragment messages, then two fragments.
        send_fragment(16'd1, 16'd1, 16'd1, 1, 1'b0);
        send_fragment(16'd31, 16'd1, 16'd1, 31, 1'b0);
        send_fragment(16'd5, 16'd1, 16'd2, 5, 1'b0);
        send_fragment(16'd7, 16'd2, 16'd2, 7, 1'b0);
        // Bad lengths: zero, one past the limit, and a nonzero high byte.
        send_fragment(16'd0, 16'd1, 16'd1, 0, 1'b0);
        send_fragment(16'd32, 16'd1, 16'd1, 0, 1'b0);
        send_fragment(16'h0105, 16'd1, 16'd1, 0, 1'b0);
        // A first fragment that is not number one, and a count of zero.
        send_fragment(16'd3, 16'd2, 16'd2, 3, 1'b0);
        send_fragment(16'd3, 16'd1, 16'd0, 3, 1'b0);
        // Sequence errors: a skipped number, then a changed count.
        send_fragment(16'd4, 16'd1, 16'd3, 4, 1'b0);
        send_fragment(16'd4, 16'd3, 16'd3, 4, 1'b0);
        send_fragment(16'd4, 16'd1, 16'd3, 4, 1'b0);
        send_fragment(16'd4, 16'd2, 16'd5, 4, 1'b0);
        // Checksum error.
        send_fragment(16'd6, 16'd1, 16'd1, 6, 1'b1);
        // Sync broken inside an open message by a plain byte.
        send_fragment(16'd2, 16'd1, 16'd2, 2, 1'b0);
        send_byte(8'h13);
        // Sync broken by a second AA, which then starts the next header.
        send_fragment(16'd2, 16'd1, 16'd2, 2, 1'b0);
        send_byte(SYNC0);
        send_fragment(16'd3, 16'd1, 16'd1, 3, 1'b0);
        // Noise while hunting gives nothing, and a clean message follows.
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(SYNC0);
        send_byte(8'h13);
        send_byte(SYNC1);
        send_fragment(16'd1, 16'd1, 16'd1, 1, 1'b0);
    endtask

    // The capacity covers the payload of the whole message plus one checksum byte.
    task automatic test_capacity_limits();
        write_capacity(len_t'(2));
        send_fragment(16'd1, 16'd1, 16'd1, 1, 1'b0);
        send_fragment(16'd2, 16'd1, 16'd1, 2, 1'b0);
        send_fragment(16'd1, 16'd1, 16'd2, 1, 1'b0);
        send_fragment(16'd1, 16'd2, 16'd2, 1, 1'b0);
        // Below two nothing fits.
        write_capacity(len_t'(1));
        send_fragment(16'd1, 16'd1, 16'd1, 1, 1'b0);
        write_capacity(len_t'(0));
        send_fragment(16'd1, 16'd1, 16'd1, 1, 1'b0);
        // Exactly full, then one byte over on the second fragment.
        write_capacity(len_t'(40));
        send_fragment(16'd20, 16'd1, 16'd2, 20, 1'b0);
        send_fragment(16'd19, 16'd2, 16'd2, 19, 1'b0);
        send_fragment(16'd20, 16'd1, 16'd2, 20, 1'b0);
        send_fragment(16'd20, 16'd2, 16'd2, 20, 1'b0);
    endtask

    // Mostly well-formed messages with random content, some damaged, and
    // bursts of noise in between.
    task automatic test_random_traffic(input int unsigned snd_pct, input int unsigned rcv_pct,
                                       input len_t cap, input int nbytes);
        int first;
        snd_idle_pct  = snd_pct;
        rcv_idle_pct <= rcv_pct;
        write_capacity(cap);
        first = bytes_sent;
        while (bytes_sent - first < nbytes)
        begin
            if ($urandom_range(7) == 0)
                send_noise($urandom_range(1, 6));
            else
                send_random_message(5, 25);
        end
    endtask

    // The receiver stops for a long stretch while bytes keep coming, so the
    // output buffer fills and the block must hold off its input.
    task automatic test_backpressure();
        write_capacity(CAP_RESET);
        fork
            hold_receiver(HOLD_CYCLES);
            repeat (4) send_random_message(3, 0);
        join
    endtask

    //------------------------------------------------------------------
    // Sequence of the run
    //------------------------------------------------------------------

    initial
    begin
        rst_n                    = 1'b0;
        rx_ch.valid              = 1'b0;
        rx_ch.rx_byte            = '0;
        cfg_ch.valid             = 1'b0;
        cfg_ch.max_message_bytes = '0;
        res_ch.ready             = 1'b0;
        reset_model();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The directed part runs with the first pacing mix.
        snd_idle_pct  = 27;
        rcv_idle_pct <= 55;
        test_directed_framing();
        test_capacity_limits();

        test_random_traffic(27, 55, len_t'($urandom_range(64, 400)), 260);
        test_random_traffic(55, 27, MSG_MAX, 260);
        test_random_traffic(0, 0, len_t'($urandom_range(2, 2047)), 260);
        test_backpressure();

        wait_idle();
        if (frame_results_due.size() != 0)
            mismatches += frame_results_due.size();

        $display("Sent %0d link bytes across %0d capacity settings; checked %0d results.",
                 bytes_sent, cap_writes + 1, results_seen);
        $display("Saw %0d completed messages and %0d aborted ones; %0d mismatches.",
                 completes_seen, aborts_seen, mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== fragmented_frame_deframer_unit.f =====
src/fdu_pkg.sv
src/fdu_rx_if.sv
src/fdu_res_if.sv
src/fdu_cfg_if.sv
src/fdu_core.sv
src/fdu_obuf.sv
src/fragmented_frame_deframer_unit.sv
verif/tb_top.sv
